>>> hw/rtl/button_debounce_press_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and press classifier
// Immediate-cycle and next-cycle property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdpc assertion failed");
// Check that cons holds in the cycle after ante
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdpc assertion failed");
`else
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons)
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the debounce and press classifier modules.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_STABLE = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [1:0] CSR_FULL_HOLD  = 2'd2;

   // Configuration reset values
   localparam logic [15:0] MIN_STABLE_RESET = 16'd20;
   localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;
   localparam logic [31:0] FULL_HOLD_RESET  = 32'd5000;

   // Event codes reported with each result beat
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_SHORT   = 3'd1,
      EV_PENDING = 3'd2,
      EV_LONG    = 3'd3,
      EV_HOLD    = 3'd4
   } event_code_type;

   // Press machine states, one-hot
   typedef enum logic [3:0] {
      ST_RELEASED = 4'b0001,
      ST_PRESSED  = 4'b0010,
      ST_LONG     = 4'b0100,
      ST_HELD     = 4'b1000
   } press_state_type;

   // Debouncer view handed to the classifier for the current sample
   typedef struct packed {
      logic        level;
      logic [31:0] time_in_level;
   } deb_status_type;

endpackage

>>> hw/rtl/bdpc_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_debounce
// Validates the contact level and tracks time spent in the validated level.
// ----------------------------------------------------------------------------
module bdpc_debounce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    pin_level,
   input  logic [31:0]             now_ms,
   input  logic [15:0]             min_stable_ms,
   output bdpc_pkg::deb_status_type status
);

   logic        validated_ff, validated_in;
   logic        prev_sample_ff, prev_sample_in;
   logic [31:0] sample_time_ff, sample_time_in;
   logic [31:0] level_time_ff, level_time_in;
   logic [31:0] time_in_level_ff, time_in_level_in;
   logic        contact;
   logic [31:0] since_sample;
   logic [31:0] since_level;

   assign contact      = ~pin_level;
   assign since_sample = now_ms - sample_time_ff;
   assign since_level  = now_ms - level_time_ff;

   // Work out the debouncer's next state for this sample
   always_comb begin
      validated_in     = validated_ff;
      prev_sample_in   = prev_sample_ff;
      sample_time_in   = sample_time_ff;
      level_time_in    = level_time_ff;
      time_in_level_in = time_in_level_ff;
      if (contact != prev_sample_ff) begin
         sample_time_in = now_ms;
         prev_sample_in = contact;
      end else if (contact == validated_ff) begin
         time_in_level_in = since_level;
      end else if (since_sample > {16'd0, min_stable_ms}) begin
         validated_in     = contact;
         level_time_in    = now_ms;
         time_in_level_in = 32'd0;
      end else begin
         time_in_level_in = since_level;
      end
   end

   // Advance the state once per accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         validated_ff     <= 1'b0;
         prev_sample_ff   <= 1'b0;
         sample_time_ff   <= 32'd0;
         level_time_ff    <= 32'd0;
         time_in_level_ff <= 32'd0;
      end else if (step) begin
         validated_ff     <= validated_in;
         prev_sample_ff   <= prev_sample_in;
         sample_time_ff   <= sample_time_in;
         level_time_ff    <= level_time_in;
         time_in_level_ff <= time_in_level_in;
      end
   end

   assign status.level         = validated_in;
   assign status.time_in_level = time_in_level_in;

endmodule

>>> hw/rtl/bdpc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_classify
// Press state machine: turns the validated level into press events.
// ----------------------------------------------------------------------------
module bdpc_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  bdpc_pkg::deb_status_type status,
   input  logic [31:0]             long_press_ms,
   input  logic [31:0]             full_hold_ms,
   output bdpc_pkg::event_code_type event_code
);

   bdpc_pkg::press_state_type state_ff, state_in;

   // Decide the next state and the event for this sample
   always_comb begin
      state_in   = state_ff;
      event_code = bdpc_pkg::EV_NONE;
      case (state_ff)
         bdpc_pkg::ST_RELEASED: begin
            if (status.level) begin
               state_in = bdpc_pkg::ST_PRESSED;
            end
         end
         bdpc_pkg::ST_PRESSED: begin
            if (!status.level) begin
               state_in   = bdpc_pkg::ST_RELEASED;
               event_code = bdpc_pkg::EV_SHORT;
            end else if (status.time_in_level > long_press_ms) begin
               state_in   = bdpc_pkg::ST_LONG;
               event_code = bdpc_pkg::EV_PENDING;
            end
         end
         bdpc_pkg::ST_LONG: begin
            if (!status.level) begin
               state_in   = bdpc_pkg::ST_RELEASED;
               event_code = bdpc_pkg::EV_LONG;
            end else if (status.time_in_level > full_hold_ms) begin
               state_in   = bdpc_pkg::ST_HELD;
               event_code = bdpc_pkg::EV_HOLD;
            end
         end
         bdpc_pkg::ST_HELD: begin
            if (!status.level) begin
               state_in = bdpc_pkg::ST_RELEASED;
            end
         end
         default: begin
            state_in = bdpc_pkg::ST_RELEASED;
         end
      endcase
   end

   // Advance the machine once per accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdpc_pkg::ST_RELEASED;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/button_debounce_press_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces an active-low button and classifies presses, one sample a beat.
// ----------------------------------------------------------------------------
// Each request beat carries one raw pin sample (0 = contact closed) with a
// wrapping millisecond timestamp, and produces exactly one response beat with
// the press event, the validated contact level and the time closed. A new
// sample is taken every clock cycle while the response is not stalled. An
// accepted sample is held in the input register, then moves on to the
// response register once that register is free. The path between the two
// registers is a 32-bit subtract, the stable-time compare that picks the new
// time in level, and the 32-bit long press or full hold compare after it. A
// stalled response holds the input register, which then holds off further
// requests. Configuration writes take effect at once and are meant for times
// when no sample is in flight.
module button_debounce_press_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pin_level,
   input  logic [31:0] req_now_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_closed,
   output logic [31:0] rsp_closed_for_ms,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   `include "button_debounce_press_classifier_unit_defines.svh"

   logic [15:0] min_stable_ff;
   logic [31:0] long_press_ff;
   logic [31:0] full_hold_ff;

   logic        in_valid_ff, in_valid_in;
   logic        in_pin_ff;
   logic [31:0] in_now_ff;

   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_event_ff;
   logic        out_closed_ff;
   logic [31:0] out_closed_for_ff;

   logic                     req_take;
   logic                     advance;
   bdpc_pkg::deb_status_type status;
   bdpc_pkg::event_code_type event_code;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_stable_ff <= bdpc_pkg::MIN_STABLE_RESET;
         long_press_ff <= bdpc_pkg::LONG_PRESS_RESET;
         full_hold_ff  <= bdpc_pkg::FULL_HOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bdpc_pkg::CSR_MIN_STABLE: min_stable_ff <= csr_write_data[15:0];
            bdpc_pkg::CSR_LONG_PRESS: long_press_ff <= csr_write_data;
            bdpc_pkg::CSR_FULL_HOLD:  full_hold_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Handshake: move the input beat on when the response register is free
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Hold the accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff <= req_pin_level;
         in_now_ff <= req_now_ms;
      end
   end

   bdpc_debounce u_debounce (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .pin_level     (in_pin_ff),
      .now_ms        (in_now_ff),
      .min_stable_ms (min_stable_ff),
      .status        (status)
   );

   bdpc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .status        (status),
      .long_press_ms (long_press_ff),
      .full_hold_ms  (full_hold_ff),
      .event_code    (event_code)
   );

   // Capture the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_event_ff      <= event_code;
         out_closed_ff     <= status.level;
         out_closed_for_ff <= status.level ? status.time_in_level : 32'd0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_code    = out_event_ff;
   assign rsp_closed        = out_closed_ff;
   assign rsp_closed_for_ms = out_closed_for_ff;

   // Open contact always reports zero closed time
   `BDPC_ASSERT_NOW(a_open_zero_time, clock, reset, out_valid_ff && !out_closed_ff, out_closed_for_ff == 32'd0)
   // Release events only come with an open contact
   `BDPC_ASSERT_NOW(a_release_open, clock, reset, out_valid_ff && (out_event_ff == bdpc_pkg::EV_SHORT || out_event_ff == bdpc_pkg::EV_LONG), !out_closed_ff)
   // Long pending and full hold only come with a closed contact
   `BDPC_ASSERT_NOW(a_hold_closed, clock, reset, out_valid_ff && (out_event_ff == bdpc_pkg::EV_PENDING || out_event_ff == bdpc_pkg::EV_HOLD), out_closed_ff)
   // A beat that cannot advance stays in the input register
   `BDPC_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // An advancing beat shows up as a response in the next cycle
   `BDPC_ASSERT_NEXT(a_advance_out, clock, reset, advance, out_valid_ff)

endmodule
